// ----- rtl/core/b64u_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and functions of the base64url stream encoder
// Holds the job word handed from the front to the back and the symbol to
// character mapping of the URL-safe alphabet.
// ----------------------------------------------------------------------------
package b64u_pkg;

    // One classified input byte: one or two 6-bit symbols to be emitted.
    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       two;
        logic       last;
    } t_job;

    // Character codes of the alphabet ranges and the two special symbols.
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam logic [6:0] LOWER_OFFSET = 7'd71;
    localparam logic [6:0] DIGIT_BACK   = 7'd4;
    localparam logic [6:0] CHAR_MINUS   = 7'd45;
    localparam logic [6:0] CHAR_UNDER   = 7'd95;

    // Map a 6-bit symbol to its URL-safe base64 character code.
    function automatic logic [6:0] sym_to_ascii(input logic [5:0] sym);
        logic [6:0] s7;
        logic [6:0] res;
        s7 = {1'b0, sym};
        if (sym < 6'd26) begin
            res = CHAR_UPPER_A + s7;
        end else if (sym < 6'd52) begin
            res = LOWER_OFFSET + s7;
        end else if (sym < 6'd62) begin
            res = s7 - DIGIT_BACK;
        end else if (sym == 6'd62) begin
            res = CHAR_MINUS;
        end else begin
            res = CHAR_UNDER;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b64u_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_front: byte classifier
// Tracks the position within the 3-byte group and the leftover bits, and
// turns each accepted byte into a job of one or two symbols.
// ----------------------------------------------------------------------------
module b64u_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_message,
    output b64u_pkg::t_job      o_job
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [3:0] r_left;
    logic [3:0] n_left;

    // Split the byte according to the group position.
    always_comb begin
        o_job  = '0;
        n_pos  = r_pos;
        n_left = r_left;
        case (r_pos)
            2'd1: begin
                o_job.sym0 = {r_left[1:0], i_data_byte[7:4]};
                o_job.sym1 = {i_data_byte[3:0], 2'b00};
                o_job.two  = i_end_of_message;
                o_job.last = i_end_of_message;
                n_left     = i_data_byte[3:0];
                n_pos      = 2'd2;
            end
            2'd2: begin
                o_job.sym0 = {r_left, i_data_byte[7:6]};
                o_job.sym1 = i_data_byte[5:0];
                o_job.two  = 1'b1;
                o_job.last = i_end_of_message;
                n_left     = 4'd0;
                n_pos      = 2'd0;
            end
            default: begin
                o_job.sym0 = i_data_byte[7:2];
                o_job.sym1 = {i_data_byte[1:0], 4'b0000};
                o_job.two  = i_end_of_message;
                o_job.last = i_end_of_message;
                n_left     = {2'b00, i_data_byte[1:0]};
                n_pos      = 2'd1;
            end
        endcase
        // The last byte of a message closes the group.
        if (i_end_of_message) begin
            n_pos  = 2'd0;
            n_left = 4'd0;
        end
    end

    // Group state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_left <= 4'd0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/b64u_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_queue: two-entry job queue
// Decouples the byte classifier from the character sequencer so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module b64u_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire b64u_pkg::t_job i_job,
    input  wire logic           i_rd,
    output b64u_pkg::t_job      o_job,
    output logic                o_valid,
    output logic                o_full
);

    b64u_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    // Storage is written at the write pointer only.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 2'd1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/b64u_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_back: character sequencer
// Takes jobs from the queue and emits their symbols one word at a time as
// characters through an output register.
// ----------------------------------------------------------------------------
module b64u_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire b64u_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_rd,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [6:0]          o_ascii_char,
    output logic                o_final_char
);

    logic       r_valid;
    logic       r_second;
    logic       n_second;
    logic [6:0] r_char;
    logic       r_final;
    logic       load;
    logic       have;
    logic [5:0] sym;
    logic       fin;

    assign o_empty      = ~r_valid;
    assign o_ascii_char = r_char;
    assign o_final_char = r_final;

    // The output register takes a new word when it is free or being taken.
    assign load = ~r_valid | i_pop;
    assign have = i_job_valid;

    // Pick the first or the second symbol of the head job.
    always_comb begin
        n_second = r_second;
        o_job_rd = 1'b0;
        if (r_second) begin
            sym = i_job.sym1;
            fin = i_job.last;
        end else begin
            sym = i_job.sym0;
            fin = 1'b0;
        end
        if (load && have) begin
            if (r_second) begin
                n_second = 1'b0;
                o_job_rd = 1'b1;
            end else if (i_job.two) begin
                n_second = 1'b1;
            end else begin
                o_job_rd = 1'b1;
            end
        end
    end

    // Control state of the sequencer and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
            if (load) begin
                r_valid <= have;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_char  <= b64u_pkg::sym_to_ascii(sym);
            r_final <= fin;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/base64url_stream_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64url_stream_encoder_unit: streaming URL-safe base64 encoder
// Encodes raw bytes into characters of the URL-safe alphabet without
// padding; the last character of each message is flagged.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Word
//  input     in         i_push / o_full  i_data_byte, i_end_of_message
//  result    out        o_empty / i_pop  o_ascii_char, o_final_char
//
//  A byte is classified in the cycle it is accepted and queued as a job.
//  The sequencer emits one character per cycle while the result side does not
//  stall, so a byte gives one or two characters on the result side; the
//  one-character result port sets the sustained byte rate in the worst case.
//  Synchronous active-low reset empties the queue and the output register.
//  Either side may stall; a two-entry job queue sits between them.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_message,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [6:0]      o_ascii_char,
    output logic            o_final_char
);

    b64u_pkg::t_job front_job;
    b64u_pkg::t_job head_job;
    logic           accept;
    logic           head_valid;
    logic           head_rd;
    logic           q_full;

    assign o_full = q_full;
    assign accept = i_push & ~q_full;

    // Front: classify each accepted byte.
    b64u_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_job            (front_job)
    );

    // Job queue between the two sides.
    b64u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .i_rd    (head_rd),
        .o_job   (head_job),
        .o_valid (head_valid),
        .o_full  (q_full)
    );

    // Back: emit characters.
    b64u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_valid  (head_valid),
        .o_job_rd     (head_rd),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_ascii_char (o_ascii_char),
        .o_final_char (o_final_char)
    );

endmodule
`default_nettype wire

// ----- rtl/core/b64u_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_checker: port-level checks of the encoder
// Watches the top-level ports and flags handshake or content slips.
// ----------------------------------------------------------------------------
module b64u_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic       o_full,
    input wire logic       i_pop,
    input wire logic       o_empty,
    input wire logic [6:0] o_ascii_char,
    input wire logic       o_final_char
);

    // A waiting word holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_ascii_char)
            && $stable(o_final_char)))
        else $error("result word changed while stalled");

    // Reset leaves both sides idle.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("not idle after reset");

    // Every shown character belongs to the URL-safe alphabet.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_ascii_char >= 7'd65 && o_ascii_char <= 7'd90)
            || (o_ascii_char >= 7'd97 && o_ascii_char <= 7'd122)
            || (o_ascii_char >= 7'd48 && o_ascii_char <= 7'd57)
            || o_ascii_char == 7'd45 || o_ascii_char == 7'd95))
        else $error("character outside alphabet");

    // A byte passes through the job queue and the output register before it
    // reaches the result ports, so with nothing pending and no byte accepted in
    // this or the previous cycle, no result appears.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !(i_push && !o_full) && !$past(i_push && !o_full))
            |=> o_empty)
        else $error("result appeared without input");

endmodule

bind base64url_stream_encoder_unit b64u_checker u_b64u_checker (.*);
`default_nettype wire
